FILE: rtl/med3lc_pkg.sv
package med3lc_pkg;

    localparam int MAX_SIZE     = 1024;
    localparam int PIXEL_BITS   = 8;
    localparam int CFG_W        = 11;
    localparam int SIZE_W       = $clog2(MAX_SIZE + 1);
    localparam int COL_W        = $clog2(MAX_SIZE);
    localparam int ROW_W        = $clog2(MAX_SIZE + 2);
    localparam int TOTAL_W      = 21;
    localparam int QUEUE_DEPTH  = 4;
    localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int BRIGHT_LIMIT = 200;
    localparam int DARK_LIMIT   = 50;
    localparam int RESET_SIZE   = (1024 > MAX_SIZE) ? MAX_SIZE : 1024;

    typedef logic [PIXEL_BITS-1:0]      pix_t;
    // One image column of three rows: index 0 is the top row.
    typedef logic [2:0][PIXEL_BITS-1:0] col_t;
    // Neighborhood in raster order: index is row * 3 + column.
    typedef logic [8:0][PIXEL_BITS-1:0] win_t;

    typedef enum logic {
        OP_PIXEL = 1'b0,
        OP_DRAIN = 1'b1
    } opcode_t;

    typedef enum logic [1:0] {
        CLASS_NORMAL = 2'd0,
        CLASS_BRIGHT = 2'd1,
        CLASS_DARK   = 2'd2
    } level_class_t;

    // Entry passed from the front end to the back end for every item that
    // moves the window, whether or not it produces a result.
    typedef struct packed {
        col_t column;
        logic emit;
        logic last;
        logic left_zero;
        logic right_zero;
        logic zero_all;
    } qent_t;

    function automatic win_t cmp_swap(win_t w, int a, int b);
        win_t r;
        r = w;
        if (w[a] > w[b]) begin
            r[a] = w[b];
            r[b] = w[a];
        end
        return r;
    endfunction

    // First half of the nine-input median network: sorts each group of three.
    function automatic win_t median_front_half(win_t w);
        win_t r;
        r = w;
        r = cmp_swap(r, 1, 2);
        r = cmp_swap(r, 4, 5);
        r = cmp_swap(r, 7, 8);
        r = cmp_swap(r, 0, 1);
        r = cmp_swap(r, 3, 4);
        r = cmp_swap(r, 6, 7);
        r = cmp_swap(r, 1, 2);
        r = cmp_swap(r, 4, 5);
        r = cmp_swap(r, 7, 8);
        return r;
    endfunction

    // Second half: merges the sorted groups down to the middle element.
    function automatic pix_t median_back_half(win_t w);
        win_t r;
        r = w;
        r = cmp_swap(r, 0, 3);
        r = cmp_swap(r, 5, 8);
        r = cmp_swap(r, 4, 7);
        r = cmp_swap(r, 3, 6);
        r = cmp_swap(r, 1, 4);
        r = cmp_swap(r, 2, 5);
        r = cmp_swap(r, 4, 7);
        r = cmp_swap(r, 4, 2);
        r = cmp_swap(r, 6, 4);
        r = cmp_swap(r, 4, 2);
        return r[4];
    endfunction

endpackage

FILE: rtl/median3x3_with_level_counts_core.sv
// Channel   | Ports                                    | Transfer when
// ----------+------------------------------------------+-------------------------
// input     | s_valid s_ready s_opcode s_pixel         | s_valid && s_ready
// result    | m_valid m_ready m_median m_level_class   | m_valid && m_ready
//           | m_*_total m_end_of_image                 |
// config    | cfg_wen cfg_wdata                        | cfg_wen
//
// One item is taken every cycle while s_ready is high; m_valid rises after the
// front register, queue, window register, two median stages and output register.
// Reset (aresetn low, synchronous) empties the pipeline and queue, clears the
// position and totals and sets the image size to 1024; line stores hold no reset.
// A stalled result holds the back end; s_ready drops once the queue is full
// and the front register holds an item.
module median3x3_with_level_counts_core (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wen,
    input  logic [med3lc_pkg::CFG_W-1:0]   cfg_wdata,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic                           s_opcode,
    input  logic [med3lc_pkg::PIXEL_BITS-1:0] s_pixel,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [med3lc_pkg::PIXEL_BITS-1:0] m_median,
    output logic [1:0]                     m_level_class,
    output logic [med3lc_pkg::TOTAL_W-1:0] m_bright_total,
    output logic [med3lc_pkg::TOTAL_W-1:0] m_dark_total,
    output logic [med3lc_pkg::TOTAL_W-1:0] m_normal_total,
    output logic                           m_end_of_image
);

    import med3lc_pkg::*;

    // Front to queue and queue to back.
    logic  push;
    qent_t push_ent;
    logic  q_full;
    logic  q_not_empty;
    qent_t q_head;
    logic  pop;

    // The front end tracks the raster position, decides which transfers
    // produce results, reads the two line stores and forms one column of
    // three pixels for every item that moves the window.
    med3lc_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_opcode  (s_opcode),
        .s_pixel   (s_pixel),
        .q_full    (q_full),
        .push      (push),
        .push_ent  (push_ent)
    );

    // The short queue lets the input side keep moving while a result stalls.
    med3lc_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_ent  (push_ent),
        .pop       (pop),
        .full      (q_full),
        .not_empty (q_not_empty),
        .head      (q_head)
    );

    // The back end shifts columns into the window, runs the two-stage median
    // network, classifies the median and keeps the per-image totals.
    med3lc_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wen        (cfg_wen),
        .q_head         (q_head),
        .q_not_empty    (q_not_empty),
        .pop            (pop),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_median       (m_median),
        .m_level_class  (m_level_class),
        .m_bright_total (m_bright_total),
        .m_dark_total   (m_dark_total),
        .m_normal_total (m_normal_total),
        .m_end_of_image (m_end_of_image)
    );

endmodule

FILE: rtl/med3lc_ram.sv
module med3lc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: rtl/med3lc_front.sv
module med3lc_front (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_wen,
    input  logic [med3lc_pkg::CFG_W-1:0] cfg_wdata,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic                         s_opcode,
    input  logic [med3lc_pkg::PIXEL_BITS-1:0] s_pixel,
    input  logic                         q_full,
    output logic                         push,
    output med3lc_pkg::qent_t            push_ent
);

    import med3lc_pkg::*;

    logic [SIZE_W-1:0] n_reg, n_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic [COL_W-1:0]  col_reg, col_next;
    logic              done_reg, done_next;
    logic              f1_valid_reg, f1_valid_next;

    logic [COL_W-1:0]  f1_col_reg;
    pix_t              f1_pixel_reg;
    logic              f1_drain_reg;
    logic              f1_emit_reg;
    logic              f1_last_reg;
    logic              f1_top_zero_reg;
    logic              f1_mid_zero_reg;
    logic              f1_left_zero_reg;
    logic              f1_right_zero_reg;
    logic              f1_zero_all_reg;

    logic              accept;
    logic              is_drain;
    logic              ignore;
    logic              take;
    logic [SIZE_W-1:0] n_minus1;
    logic [SIZE_W-1:0] cfg_size;
    logic              col_last;
    logic              row_last;
    logic              emit;
    logic              last;
    pix_t              up_rdata;
    pix_t              mid_rdata;

    assign push     = f1_valid_reg && !q_full;
    assign s_ready  = !f1_valid_reg || !q_full;
    assign accept   = s_valid && s_ready;
    assign is_drain = (s_opcode == OP_DRAIN);
    // Drains count only after the whole image is in; pixels only before.
    assign ignore   = is_drain ? !done_reg : done_reg;
    assign take     = accept && !ignore;

    assign n_minus1 = n_reg - SIZE_W'(1);
    assign col_last = (SIZE_W'(col_reg) == n_minus1);
    assign row_last = (row_reg == ROW_W'(n_minus1));
    assign emit     = is_drain || (row_reg >= ROW_W'(2)) ||
                      ((row_reg == ROW_W'(1)) && (col_reg != '0));
    assign last     = is_drain && ((row_reg == ROW_W'(n_reg) + ROW_W'(1)) ||
                                   (n_reg == SIZE_W'(1)));

    assign cfg_size = (cfg_wdata == '0) ? SIZE_W'(1) :
                      (32'(cfg_wdata) > MAX_SIZE) ? SIZE_W'(MAX_SIZE) :
                      SIZE_W'(cfg_wdata);

    always_comb begin
        n_next        = n_reg;
        row_next      = row_reg;
        col_next      = col_reg;
        done_next     = done_reg;
        f1_valid_next = f1_valid_reg;
        if (push) begin
            f1_valid_next = 1'b0;
        end
        if (take) begin
            f1_valid_next = 1'b1;
        end
        if (cfg_wen) begin
            n_next    = cfg_size;
            row_next  = '0;
            col_next  = '0;
            done_next = 1'b0;
        end else if (take) begin
            if (last) begin
                row_next  = '0;
                col_next  = '0;
                done_next = 1'b0;
            end else if (col_last) begin
                col_next = '0;
                row_next = row_reg + ROW_W'(1);
                if (!is_drain && row_last) begin
                    done_next = 1'b1;
                end
            end else begin
                col_next = col_reg + COL_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            n_reg        <= SIZE_W'(RESET_SIZE);
            row_reg      <= '0;
            col_reg      <= '0;
            done_reg     <= 1'b0;
            f1_valid_reg <= 1'b0;
        end else begin
            n_reg        <= n_next;
            row_reg      <= row_next;
            col_reg      <= col_next;
            done_reg     <= done_next;
            f1_valid_reg <= f1_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            f1_col_reg        <= col_reg;
            f1_pixel_reg      <= s_pixel;
            f1_drain_reg      <= is_drain;
            f1_emit_reg       <= emit;
            f1_last_reg       <= last;
            f1_top_zero_reg   <= (row_reg < ROW_W'(2));
            f1_mid_zero_reg   <= (row_reg == '0);
            f1_left_zero_reg  <= (col_reg == COL_W'(1));
            f1_right_zero_reg <= (col_reg == '0);
            f1_zero_all_reg   <= (n_reg == SIZE_W'(1));
        end
    end

    // Upper holds the row two above the input, middle the row just above.
    med3lc_ram #(.WIDTH(PIXEL_BITS), .DEPTH(MAX_SIZE)) u_line_upper (
        .aclk    (aclk),
        .wr_en   (push && !f1_drain_reg),
        .wr_addr (f1_col_reg),
        .wr_data (mid_rdata),
        .rd_en   (take),
        .rd_addr (col_reg),
        .rd_data (up_rdata)
    );

    med3lc_ram #(.WIDTH(PIXEL_BITS), .DEPTH(MAX_SIZE)) u_line_middle (
        .aclk    (aclk),
        .wr_en   (push && !f1_drain_reg),
        .wr_addr (f1_col_reg),
        .wr_data (f1_pixel_reg),
        .rd_en   (take),
        .rd_addr (col_reg),
        .rd_data (mid_rdata)
    );

    always_comb begin
        push_ent.column[0] = f1_top_zero_reg ? '0 : up_rdata;
        push_ent.column[1] = f1_mid_zero_reg ? '0 : mid_rdata;
        push_ent.column[2] = f1_drain_reg ? '0 : f1_pixel_reg;
        push_ent.emit       = f1_emit_reg;
        push_ent.last       = f1_last_reg;
        push_ent.left_zero  = f1_left_zero_reg;
        push_ent.right_zero = f1_right_zero_reg;
        push_ent.zero_all   = f1_zero_all_reg;
    end

endmodule

FILE: rtl/med3lc_queue.sv
module med3lc_queue (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  med3lc_pkg::qent_t push_ent,
    input  logic              pop,
    output logic              full,
    output logic              not_empty,
    output med3lc_pkg::qent_t head
);

    import med3lc_pkg::*;

    qent_t             mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wptr_reg, wptr_next;
    logic [QPTR_W-1:0] rptr_reg, rptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;

    assign full      = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = mem_reg[rptr_reg];

    always_comb begin
        wptr_next  = wptr_reg;
        rptr_next  = rptr_reg;
        count_next = count_reg;
        if (push) begin
            wptr_next = (wptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wptr_reg + QPTR_W'(1);
        end
        if (pop) begin
            rptr_next = (rptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rptr_reg + QPTR_W'(1);
        end
        if (push && !pop) begin
            count_next = count_reg + QCNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end else begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wptr_reg] <= push_ent;
        end
    end

endmodule

FILE: rtl/med3lc_back.sv
module med3lc_back (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wen,
    input  med3lc_pkg::qent_t              q_head,
    input  logic                           q_not_empty,
    output logic                           pop,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [med3lc_pkg::PIXEL_BITS-1:0] m_median,
    output logic [1:0]                     m_level_class,
    output logic [med3lc_pkg::TOTAL_W-1:0] m_bright_total,
    output logic [med3lc_pkg::TOTAL_W-1:0] m_dark_total,
    output logic [med3lc_pkg::TOTAL_W-1:0] m_normal_total,
    output logic                           m_end_of_image
);

    import med3lc_pkg::*;

    logic                adv;
    col_t                col1_reg;
    col_t                col2_reg;
    win_t                win;

    logic                b0_valid_reg;
    logic                b0_last_reg;
    win_t                win0_reg;
    logic                b1_valid_reg;
    logic                b1_last_reg;
    win_t                st1_reg;
    logic                b2_valid_reg;
    logic                b2_last_reg;
    pix_t                med2_reg;

    logic                m_valid_reg;
    pix_t                m_median_reg;
    level_class_t        m_class_reg;
    logic [TOTAL_W-1:0]  m_bright_reg;
    logic [TOTAL_W-1:0]  m_dark_reg;
    logic [TOTAL_W-1:0]  m_normal_reg;
    logic                m_last_reg;

    logic [TOTAL_W-1:0]  bright_reg, bright_next;
    logic [TOTAL_W-1:0]  dark_reg, dark_next;
    logic [TOTAL_W-1:0]  normal_reg, normal_next;

    level_class_t        cls;
    logic [TOTAL_W-1:0]  bright_new;
    logic [TOTAL_W-1:0]  dark_new;
    logic [TOTAL_W-1:0]  normal_new;

    assign adv = !m_valid_reg || m_ready;
    assign pop = adv && q_not_empty;

    // Window columns: at the start of a row the right column is past the edge.
    always_comb begin
        win = '0;
        if (!q_head.zero_all) begin
            for (int r = 0; r < 3; r++) begin
                if (q_head.right_zero) begin
                    win[r * 3]     = col2_reg[r];
                    win[r * 3 + 1] = col1_reg[r];
                end else begin
                    win[r * 3]     = q_head.left_zero ? '0 : col2_reg[r];
                    win[r * 3 + 1] = col1_reg[r];
                    win[r * 3 + 2] = q_head.column[r];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            col1_reg <= q_head.column;
            col2_reg <= col1_reg;
        end
        if (adv) begin
            win0_reg    <= win;
            b0_last_reg <= q_head.last;
            st1_reg     <= median_front_half(win0_reg);
            b1_last_reg <= b0_last_reg;
            med2_reg    <= median_back_half(st1_reg);
            b2_last_reg <= b1_last_reg;
        end
        if (adv && b2_valid_reg) begin
            m_median_reg <= med2_reg;
            m_class_reg  <= cls;
            m_bright_reg <= bright_new;
            m_dark_reg   <= dark_new;
            m_normal_reg <= normal_new;
            m_last_reg   <= b2_last_reg;
        end
    end

    always_comb begin
        if (med2_reg > pix_t'(BRIGHT_LIMIT)) begin
            cls = CLASS_BRIGHT;
        end else if (med2_reg < pix_t'(DARK_LIMIT)) begin
            cls = CLASS_DARK;
        end else begin
            cls = CLASS_NORMAL;
        end
    end

    assign bright_new = bright_reg + TOTAL_W'(cls == CLASS_BRIGHT);
    assign dark_new   = dark_reg + TOTAL_W'(cls == CLASS_DARK);
    assign normal_new = normal_reg + TOTAL_W'(cls == CLASS_NORMAL);

    always_comb begin
        bright_next = bright_reg;
        dark_next   = dark_reg;
        normal_next = normal_reg;
        if (cfg_wen || (adv && b2_valid_reg && b2_last_reg)) begin
            bright_next = '0;
            dark_next   = '0;
            normal_next = '0;
        end else if (adv && b2_valid_reg) begin
            bright_next = bright_new;
            dark_next   = dark_new;
            normal_next = normal_new;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b0_valid_reg <= 1'b0;
            b1_valid_reg <= 1'b0;
            b2_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            bright_reg   <= '0;
            dark_reg     <= '0;
            normal_reg   <= '0;
        end else begin
            if (adv) begin
                b0_valid_reg <= pop && q_head.emit;
                b1_valid_reg <= b0_valid_reg;
                b2_valid_reg <= b1_valid_reg;
                m_valid_reg  <= b2_valid_reg;
            end
            bright_reg <= bright_next;
            dark_reg   <= dark_next;
            normal_reg <= normal_next;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_median       = m_median_reg;
    assign m_level_class  = m_class_reg;
    assign m_bright_total = m_bright_reg;
    assign m_dark_total   = m_dark_reg;
    assign m_normal_total = m_normal_reg;
    assign m_end_of_image = m_last_reg;

endmodule

FILE: rtl/med3lc_checker.sv
module med3lc_checker (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           m_valid,
    input  logic                           m_ready,
    input  logic [med3lc_pkg::PIXEL_BITS-1:0] m_median,
    input  logic [1:0]                     m_level_class,
    input  logic [med3lc_pkg::TOTAL_W-1:0] m_bright_total,
    input  logic [med3lc_pkg::TOTAL_W-1:0] m_dark_total,
    input  logic [med3lc_pkg::TOTAL_W-1:0] m_normal_total,
    input  logic                           m_end_of_image
);

    import med3lc_pkg::*;

    logic [TOTAL_W+1:0] tot_sum;

    assign tot_sum = (TOTAL_W + 2)'(m_bright_total) + (TOTAL_W + 2)'(m_dark_total) +
                     (TOTAL_W + 2)'(m_normal_total);

    // A result waiting on the output holds its payload.
    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_median) && $stable(tot_sum) &&
                                $stable(m_level_class) && $stable(m_end_of_image))
        else $error("result changed while stalled");

    // Reset leaves no result on the output.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // Within an image, back-to-back results raise the totals by exactly one.
    a_totals_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && !m_end_of_image) ##1 (m_valid && m_ready)
        |-> tot_sum == $past(tot_sum) + (TOTAL_W + 2)'(1))
        else $error("totals did not advance by one");

    // The result right after the end of an image starts the totals afresh.
    a_totals_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && m_end_of_image) ##1 m_valid
        |-> tot_sum == (TOTAL_W + 2)'(1))
        else $error("totals not restarted after end of image");

endmodule

bind median3x3_with_level_counts_core med3lc_checker u_med3lc_checker (.*);
